>>> design/rbow_pkg.sv
// Shared constants, request codes and controller/datapath link types for the ring buffer.
package rbow_pkg;

    localparam int BUF_DEPTH = 1024;
    localparam int MAX_BURST = 64;

    localparam int PTR_W  = $clog2(BUF_DEPTH);
    localparam int OCC_W  = $clog2(BUF_DEPTH + 1);
    localparam int LEN_W  = 7;
    localparam int OFS_W  = 10;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_POP   = 2'd3
    } req_t;

    typedef struct packed {
        logic start;
        logic fetch;
    } cmd_t;

    typedef struct packed {
        logic stream_req;
        logic last_fetch;
    } stat_t;

endpackage

>>> design/rbow_ctrl.sv
// Controller state machine: request transfers, byte streaming and output valid.
module rbow_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  rbow_pkg::stat_t stat,
    output rbow_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_STREAM = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.start      = 1'b0;
        cmd.fetch      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    cmd.start = 1'b1;
                    if (stat.stream_req)
                    begin
                        state_next = ST_STREAM;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_STREAM:
            begin
                if (out_free)
                begin
                    cmd.fetch      = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.last_fetch)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/rbow_dpath.sv
// Datapath: byte store, head and tail pointers, full flag, burst counters and result registers.
module rbow_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbow_pkg::cmd_t                cmd,
    output rbow_pkg::stat_t               stat,
    input  logic [rbow_pkg::REQ_W-1:0]    req_type,
    input  logic [rbow_pkg::OFS_W-1:0]    offset,
    input  logic [rbow_pkg::BYTE_W-1:0]   data_byte,
    input  logic [rbow_pkg::LEN_W-1:0]    length,
    output logic [rbow_pkg::BYTE_W-1:0]   byte_out,
    output logic                          byte_valid,
    output logic                          last,
    output logic                          accepted,
    output logic [rbow_pkg::LEN_W-1:0]    moved_count,
    output logic [rbow_pkg::OCC_W-1:0]    occupancy,
    output logic                          is_full,
    output logic                          is_empty
);

    localparam int PW = rbow_pkg::PTR_W;
    localparam int OW = rbow_pkg::OCC_W;
    localparam int LW = rbow_pkg::LEN_W;

    logic [rbow_pkg::BYTE_W-1:0] mem [rbow_pkg::BUF_DEPTH];

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic          full_reg, full_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [LW-1:0] remain_reg;
    logic [LW-1:0] burst_reg;

    logic [rbow_pkg::BYTE_W-1:0] byte_q;
    logic          bvalid_reg;
    logic          last_reg;
    logic          acc_reg;
    logic [LW-1:0] moved_reg;

    rbow_pkg::req_t req;
    logic [OW-1:0] used;
    logic [OW-1:0] free_cnt;
    logic          wr_ok;
    logic          wr_en;
    logic [PW:0]   wr_sum;
    logic [PW-1:0] wr_pos;
    logic [PW-1:0] head_inc;
    logic [LW-1:0] len_sat;
    logic [LW-1:0] n;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] tail_new;
    logic [PW-1:0] rd_inc;

    assign req = rbow_pkg::req_t'(req_type);

    always_comb
    begin
        if (full_reg)
        begin
            used = OW'(rbow_pkg::BUF_DEPTH);
        end
        else if (head_reg >= tail_reg)
        begin
            used = OW'(head_reg) - OW'(tail_reg);
        end
        else
        begin
            used = OW'(rbow_pkg::BUF_DEPTH) - OW'(tail_reg) + OW'(head_reg);
        end
    end

    assign free_cnt = OW'(rbow_pkg::BUF_DEPTH) - used;
    assign wr_ok    = !full_reg && (OW'(offset) < free_cnt);
    assign wr_en    = cmd.start && (req == rbow_pkg::REQ_WRITE) && wr_ok;

    assign wr_sum = (PW+1)'(head_reg) + (PW+1)'(offset);
    assign wr_pos = (wr_sum >= (PW+1)'(rbow_pkg::BUF_DEPTH))
                  ? PW'(wr_sum - (PW+1)'(rbow_pkg::BUF_DEPTH)) : PW'(wr_sum);

    assign head_inc = (head_reg == PW'(rbow_pkg::BUF_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign rd_inc   = (rd_ptr_reg == PW'(rbow_pkg::BUF_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign len_sat = (length > LW'(rbow_pkg::MAX_BURST)) ? LW'(rbow_pkg::MAX_BURST) : length;
    assign n       = (OW'(len_sat) < used) ? len_sat : LW'(used);

    assign tail_sum = (PW+1)'(tail_reg) + (PW+1)'(n);
    assign tail_new = (tail_sum >= (PW+1)'(rbow_pkg::BUF_DEPTH))
                    ? PW'(tail_sum - (PW+1)'(rbow_pkg::BUF_DEPTH)) : PW'(tail_sum);

    assign stat.stream_req = ((req == rbow_pkg::REQ_READ) || (req == rbow_pkg::REQ_PEEK))
                           && (n != '0);
    assign stat.last_fetch = (remain_reg == LW'(1));

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        full_next = full_reg;
        if (cmd.start)
        begin
            case (req)
                rbow_pkg::REQ_WRITE:
                begin
                    if (wr_ok && (offset == '0))
                    begin
                        head_next = head_inc;
                        full_next = (head_inc == tail_reg);
                    end
                end
                rbow_pkg::REQ_READ, rbow_pkg::REQ_POP:
                begin
                    if (n != '0)
                    begin
                        tail_next = tail_new;
                        full_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            full_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            full_reg <= full_next;
            if (cmd.start)
            begin
                remain_reg <= n;
            end
            else if (cmd.fetch)
            begin
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rd_ptr_reg <= tail_reg;
            burst_reg  <= n;
            bvalid_reg <= 1'b0;
            last_reg   <= 1'b1;
            acc_reg    <= (req == rbow_pkg::REQ_WRITE) ? wr_ok : (n != '0);
            moved_reg  <= (req == rbow_pkg::REQ_POP) ? n : '0;
        end
        else if (cmd.fetch)
        begin
            rd_ptr_reg <= rd_inc;
            bvalid_reg <= 1'b1;
            last_reg   <= stat.last_fetch;
            acc_reg    <= 1'b1;
            moved_reg  <= stat.last_fetch ? burst_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_pos] <= data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            byte_q <= mem[rd_ptr_reg];
        end
    end

    assign byte_out    = bvalid_reg ? byte_q : '0;
    assign byte_valid  = bvalid_reg;
    assign last        = last_reg;
    assign accepted    = acc_reg;
    assign moved_count = moved_reg;
    assign occupancy   = used;
    assign is_full     = full_reg;
    assign is_empty    = (used == '0);

endmodule

>>> design/ring_buffer_offset_write.sv
// Byte ring buffer with offset writes, burst read, peek and pop: top level.
// Write, pop and empty-burst requests give one result one cycle after the input transfer.
// Read and peek give their first byte two cycles after the transfer, then one byte per cycle
// from the single read port of the byte store, as long as the output is not stalled.
// A new request is taken once the last result of the previous one leaves the output register.
// Reset clears head, tail and the full flag at once; the byte store is not cleared.
module ring_buffer_offset_write
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rbow_pkg::REQ_W-1:0]    req_type,
    input  logic [rbow_pkg::OFS_W-1:0]    offset,
    input  logic [rbow_pkg::BYTE_W-1:0]   data_byte,
    input  logic [rbow_pkg::LEN_W-1:0]    length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rbow_pkg::BYTE_W-1:0]   byte_out,
    output logic                          byte_valid,
    output logic                          last,
    output logic                          accepted,
    output logic [rbow_pkg::LEN_W-1:0]    moved_count,
    output logic [rbow_pkg::OCC_W-1:0]    occupancy,
    output logic                          is_full,
    output logic                          is_empty
);

    rbow_pkg::cmd_t  cmd;
    rbow_pkg::stat_t stat;

    rbow_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rbow_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .offset      (offset),
        .data_byte   (data_byte),
        .length      (length),
        .byte_out    (byte_out),
        .byte_valid  (byte_valid),
        .last        (last),
        .accepted    (accepted),
        .moved_count (moved_count),
        .occupancy   (occupancy),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

endmodule

>>> design/rbow_checker.sv
// Port-level checker for the ring buffer and its bind to the top level.
module rbow_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [rbow_pkg::BYTE_W-1:0]   byte_out,
    input logic                          byte_valid,
    input logic                          last,
    input logic [rbow_pkg::LEN_W-1:0]    moved_count,
    input logic [rbow_pkg::OCC_W-1:0]    occupancy,
    input logic                          is_full
);

    // A stalled result keeps its byte.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(last))
        else $error("stalled result changed");

    // A burst keeps streaming once a non-final byte has been taken.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && byte_valid)
        else $error("burst broke off before its last byte");

    // A result without a byte is always the only result of its request.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last)
        else $error("byte-less result not marked last");

    // The final byte of a burst reports a nonzero count.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid && last |-> moved_count != '0)
        else $error("burst ended with zero count");

    // The full flag agrees with the reported occupancy.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_full == (occupancy == rbow_pkg::OCC_W'(rbow_pkg::BUF_DEPTH)))
        else $error("full flag and occupancy disagree");

endmodule

bind ring_buffer_offset_write rbow_checker u_rbow_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_out    (byte_out),
    .byte_valid  (byte_valid),
    .last        (last),
    .moved_count (moved_count),
    .occupancy   (occupancy),
    .is_full     (is_full)
);

>>> sim/tb_ring_buffer_offset_write.sv
// Self-checking testbench for the offset-write byte ring buffer, with its own buffer predictor.
module tb_ring_buffer_offset_write;

    localparam int IDLE_LIMIT  = 4000;
    localparam int RANDOM_REQS = 140;

    typedef struct {
        logic [rbow_pkg::BYTE_W-1:0] byte_out;
        logic                        byte_valid;
        logic                        last;
        logic                        accepted;
        logic [rbow_pkg::LEN_W-1:0]  moved_count;
        logic [rbow_pkg::OCC_W-1:0]  occupancy;
        logic                        is_full;
        logic                        is_empty;
    } status_t;

    typedef struct {
        rbow_pkg::req_t              req;
        logic [rbow_pkg::OFS_W-1:0]  ofs;
        logic [rbow_pkg::BYTE_W-1:0] data;
        logic [rbow_pkg::LEN_W-1:0]  len;
        logic                        typed;
        logic                        exp_acc;
        int                          exp_occ;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [rbow_pkg::REQ_W-1:0]  req_type;
    logic [rbow_pkg::OFS_W-1:0]  offset;
    logic [rbow_pkg::BYTE_W-1:0] data_byte;
    logic [rbow_pkg::LEN_W-1:0]  length;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [rbow_pkg::BYTE_W-1:0] byte_out;
    logic                        byte_valid;
    logic                        last;
    logic                        accepted;
    logic [rbow_pkg::LEN_W-1:0]  moved_count;
    logic [rbow_pkg::OCC_W-1:0]  occupancy;
    logic                        is_full;
    logic                        is_empty;

    logic [rbow_pkg::BYTE_W-1:0] ring_bytes [rbow_pkg::BUF_DEPTH];
    int                head_idx;
    int                tail_idx;
    logic              ring_full;
    status_t           due_results [$];

    int   error_count;
    int   idle_cycles;
    int   burst_left;
    int   stall_mode;
    int   stall_left;
    int   stall_phase;
    logic row_typed;
    logic row_acc;
    int   row_occ;

    stim_row_t directed_rows [19] = '{
        '{rbow_pkg::REQ_READ,  10'd0,    8'h00, 7'd5,   1'b1, 1'b0, 0},
        '{rbow_pkg::REQ_PEEK,  10'd0,    8'h00, 7'd0,   1'b1, 1'b0, 0},
        '{rbow_pkg::REQ_POP,   10'd0,    8'h00, 7'd64,  1'b1, 1'b0, 0},
        '{rbow_pkg::REQ_WRITE, 10'd1023, 8'hAA, 7'd0,   1'b1, 1'b1, 0},
        '{rbow_pkg::REQ_WRITE, 10'd0,    8'h00, 7'd0,   1'b1, 1'b1, 1},
        '{rbow_pkg::REQ_WRITE, 10'd1023, 8'h11, 7'd0,   1'b1, 1'b0, 1},
        '{rbow_pkg::REQ_WRITE, 10'd1022, 8'h55, 7'd0,   1'b1, 1'b1, 1},
        '{rbow_pkg::REQ_WRITE, 10'd0,    8'hFF, 7'd0,   1'b1, 1'b1, 2},
        '{rbow_pkg::REQ_WRITE, 10'd0,    8'h5A, 7'd0,   1'b1, 1'b1, 3},
        '{rbow_pkg::REQ_WRITE, 10'd0,    8'hA5, 7'd0,   1'b1, 1'b1, 4},
        '{rbow_pkg::REQ_PEEK,  10'd0,    8'h00, 7'd0,   1'b1, 1'b0, 4},
        '{rbow_pkg::REQ_PEEK,  10'd0,    8'h00, 7'd2,   1'b0, 1'b0, 0},
        '{rbow_pkg::REQ_PEEK,  10'd0,    8'h00, 7'd127, 1'b0, 1'b0, 0},
        '{rbow_pkg::REQ_READ,  10'd0,    8'h00, 7'd1,   1'b0, 1'b0, 0},
        '{rbow_pkg::REQ_POP,   10'd0,    8'h00, 7'd1,   1'b1, 1'b1, 2},
        '{rbow_pkg::REQ_READ,  10'd0,    8'h00, 7'd100, 1'b0, 1'b0, 0},
        '{rbow_pkg::REQ_READ,  10'd0,    8'h00, 7'd1,   1'b1, 1'b0, 0},
        '{rbow_pkg::REQ_WRITE, 10'd0,    8'h3C, 7'd0,   1'b1, 1'b1, 1},
        '{rbow_pkg::REQ_POP,   10'd0,    8'h00, 7'd127, 1'b1, 1'b1, 0}
    };

    ring_buffer_offset_write u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .offset      (offset),
        .data_byte   (data_byte),
        .length      (length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_out    (byte_out),
        .byte_valid  (byte_valid),
        .last        (last),
        .accepted    (accepted),
        .moved_count (moved_count),
        .occupancy   (occupancy),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int stored_count();
        if (ring_full)
            return rbow_pkg::BUF_DEPTH;
        if (head_idx >= tail_idx)
            return head_idx - tail_idx;
        return rbow_pkg::BUF_DEPTH - tail_idx + head_idx;
    endfunction

    function automatic void queue_status(status_t r);
        int used;
        used = stored_count();
        r.occupancy = rbow_pkg::OCC_W'(used);
        r.is_full = ring_full;
        r.is_empty = (used == 0);
        due_results.push_back(r);
    endfunction

    function automatic void apply_request(rbow_pkg::req_t rq, logic [rbow_pkg::OFS_W-1:0] ofs,
                                          logic [rbow_pkg::BYTE_W-1:0] d,
                                          logic [rbow_pkg::LEN_W-1:0] len);
        status_t r;
        int used;
        int n;
        int start;
        used = stored_count();
        r = '{default: '0};
        r.last = 1'b1;
        if (rq == rbow_pkg::REQ_WRITE)
        begin
            if (!ring_full && int'(ofs) < rbow_pkg::BUF_DEPTH - used)
            begin
                ring_bytes[rbow_pkg::PTR_W'((head_idx + int'(ofs)) % rbow_pkg::BUF_DEPTH)] = d;
                if (ofs == 0)
                begin
                    head_idx = (head_idx + 1) % rbow_pkg::BUF_DEPTH;
                    if (head_idx == tail_idx)
                        ring_full = 1'b1;
                end
                r.accepted = 1'b1;
            end
            queue_status(r);
            return;
        end
        n = (int'(len) > rbow_pkg::MAX_BURST) ? rbow_pkg::MAX_BURST : int'(len);
        if (n > used)
            n = used;
        if (n == 0)
        begin
            queue_status(r);
            return;
        end
        start = tail_idx;
        if (rq != rbow_pkg::REQ_PEEK)
        begin
            tail_idx = (tail_idx + n) % rbow_pkg::BUF_DEPTH;
            ring_full = 1'b0;
        end
        r.accepted = 1'b1;
        if (rq == rbow_pkg::REQ_POP)
        begin
            r.moved_count = rbow_pkg::LEN_W'(n);
            queue_status(r);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            r.byte_out = ring_bytes[rbow_pkg::PTR_W'((start + i) % rbow_pkg::BUF_DEPTH)];
            r.byte_valid = 1'b1;
            r.last = (i == n - 1);
            r.moved_count = (i == n - 1) ? rbow_pkg::LEN_W'(n) : '0;
            queue_status(r);
        end
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic send_request(rbow_pkg::req_t rq, logic [rbow_pkg::OFS_W-1:0] ofs,
                                logic [rbow_pkg::BYTE_W-1:0] d,
                                logic [rbow_pkg::LEN_W-1:0] len, logic typed, logic acc,
                                int occ);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        row_typed = typed;
        row_acc = acc;
        row_occ = occ;
        req_type <= rq;
        offset <= ofs;
        data_byte <= d;
        length <= len;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic random_request();
        int pick;
        int free_space;
        logic [rbow_pkg::LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) < 7) ? rbow_pkg::LEN_W'($urandom_range(0, 8))
            : ($urandom_range(0, 2) < 2) ? rbow_pkg::LEN_W'($urandom_range(0, 70))
            : rbow_pkg::LEN_W'($urandom_range(64, 127));
        if (pick < 55)
        begin
            free_space = rbow_pkg::BUF_DEPTH - stored_count();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pick = 0;
            else if (pick < 85)
            begin
                pick = free_space - int'($urandom_range(0, 1));
                if (pick < 0)
                    pick = 0;
                if (pick > rbow_pkg::BUF_DEPTH - 1)
                    pick = rbow_pkg::BUF_DEPTH - 1;
            end
            else
                pick = $urandom_range(0, rbow_pkg::BUF_DEPTH - 1);
            send_request(rbow_pkg::REQ_WRITE, rbow_pkg::OFS_W'(pick),
                         rbow_pkg::BYTE_W'($urandom), len, 1'b0, 1'b0, 0);
        end
        else if (pick < 70)
            send_request(rbow_pkg::REQ_READ, rbow_pkg::OFS_W'($urandom),
                         rbow_pkg::BYTE_W'($urandom), len, 1'b0, 1'b0, 0);
        else if (pick < 85)
            send_request(rbow_pkg::REQ_PEEK, rbow_pkg::OFS_W'($urandom),
                         rbow_pkg::BYTE_W'($urandom), len, 1'b0, 1'b0, 0);
        else
            send_request(rbow_pkg::REQ_POP, rbow_pkg::OFS_W'($urandom),
                         rbow_pkg::BYTE_W'($urandom), len, 1'b0, 1'b0, 0);
    endtask

    always @(posedge clk)
    begin
        status_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                apply_request(rbow_pkg::req_t'(req_type), offset, data_byte, length);
                if (row_typed)
                begin
                    r = due_results.pop_back();
                    r.accepted = row_acc;
                    r.occupancy = rbow_pkg::OCC_W'(row_occ);
                    due_results.push_back(r);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result transfer expected none, actual byte_out %0d last %0d",
                             $time, byte_out, last);
                    error_count++;
                end
                else
                begin
                    r = due_results.pop_front();
                    check_field("byte_out", 16'(r.byte_out), 16'(byte_out));
                    check_field("byte_valid", 16'(r.byte_valid), 16'(byte_valid));
                    check_field("last", 16'(r.last), 16'(last));
                    check_field("accepted", 16'(r.accepted), 16'(accepted));
                    check_field("moved_count", 16'(r.moved_count), 16'(moved_count));
                    check_field("occupancy", 16'(r.occupancy), 16'(occupancy));
                    check_field("is_full", 16'(r.is_full), 16'(is_full));
                    check_field("is_empty", 16'(r.is_empty), 16'(is_empty));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        stall_phase = (stall_phase + 1) % 3;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= (stall_phase == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        stall_phase = 0;
        row_typed = 1'b0;
        row_acc = 1'b0;
        row_occ = 0;
        head_idx = 0;
        tail_idx = 0;
        ring_full = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = rbow_pkg::REQ_WRITE;
        offset = '0;
        data_byte = '0;
        length = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].ofs, directed_rows[i].data,
                         directed_rows[i].len, directed_rows[i].typed,
                         directed_rows[i].exp_acc, directed_rows[i].exp_occ);

        repeat (RANDOM_REQS)
            random_request();

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
